@@ rtl/bpf_pkg.sv @@
// shared types, constants and tables for the branch power flow pipeline
package bpf_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned XyW         = 20;
  localparam int unsigned ZW          = 20;
  localparam int unsigned DivBits     = 47;
  localparam int unsigned RemW        = 16;

  localparam logic signed [17:0] Q13Pi     = 18'sd25736;
  localparam logic signed [17:0] Q13HalfPi = 18'sd12868;
  localparam logic signed [17:0] Q13TwoPi  = 18'sd51472;
  localparam logic signed [XyW-1:0] CordicGain = 20'sd39797;
  localparam logic signed [XyW-1:0] OneQ16     = 20'sd65536;
  localparam logic [15:0] TapOne = 16'd16384;

  // arctan(2^-i) in q16
  function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      4'd0:    r = 20'sd51472;
      4'd1:    r = 20'sd30386;
      4'd2:    r = 20'sd16055;
      4'd3:    r = 20'sd8150;
      4'd4:    r = 20'sd4091;
      4'd5:    r = 20'sd2047;
      4'd6:    r = 20'sd1024;
      4'd7:    r = 20'sd512;
      4'd8:    r = 20'sd256;
      4'd9:    r = 20'sd128;
      4'd10:   r = 20'sd64;
      4'd11:   r = 20'sd32;
      4'd12:   r = 20'sd16;
      4'd13:   r = 20'sd8;
      4'd14:   r = 20'sd4;
      4'd15:   r = 20'sd2;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [31:0]        vff;
    logic [31:0]        vtt;
    logic [31:0]        vft;
    logic signed [23:0] g;
    logic signed [23:0] b;
    logic signed [24:0] bb;
    logic [15:0]        t;
    logic               neg;
  } cord_side_t;

  typedef struct packed {
    logic [RemW-1:0]    rem;
    logic [DivBits-1:0] num;
    logic               neg;
  } div_lane_t;

  typedef struct packed {
    logic signed [33:0] cr_fp;
    logic signed [33:0] cr_fq;
    logic signed [33:0] cr_tp;
    logic signed [33:0] cr_tq;
    logic signed [35:0] self_tp;
    logic signed [35:0] self_tq;
    logic [15:0]        t;
  } div_side_t;

endpackage

@@ rtl/bpf_cordic_cell.sv @@
// one rotation step of the cos/sin chain
module bpf_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic signed [bpf_pkg::XyW-1:0]  x_i,
  input  logic signed [bpf_pkg::XyW-1:0]  y_i,
  input  logic signed [bpf_pkg::ZW-1:0]   z_i,
  input  bpf_pkg::cord_side_t             side_i,
  output logic                            vld_o,
  output logic signed [bpf_pkg::XyW-1:0]  x_o,
  output logic signed [bpf_pkg::XyW-1:0]  y_o,
  output logic signed [bpf_pkg::ZW-1:0]   z_o,
  output bpf_pkg::cord_side_t             side_o
);
  import bpf_pkg::*;

  logic                   vld_q;
  logic signed [XyW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]   z_q, z_d;
  cord_side_t             side_q;
  logic signed [XyW-1:0]  xs, ys;
  logic signed [ZW-1:0]   ang;

  always_comb begin
    xs  = x_i >>> Step;
    ys  = y_i >>> Step;
    ang = atan_q16(4'(Step));
    if (z_i >= 0) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ang;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

  // rotated vector never leaves the 18 bit range
  a_xy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (x_q < 20'sd131072 && x_q > -20'sd131072 &&
               y_q < 20'sd131072 && y_q > -20'sd131072))
    else $error("cordic vector out of range");

endmodule

@@ rtl/bpf_div_cell.sv @@
// one quotient bit of the two restoring dividers
module bpf_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  bpf_pkg::div_lane_t   lane_p_i,
  input  bpf_pkg::div_lane_t   lane_q_i,
  input  bpf_pkg::div_side_t   side_i,
  output logic                 vld_o,
  output bpf_pkg::div_lane_t   lane_p_o,
  output bpf_pkg::div_lane_t   lane_q_o,
  output bpf_pkg::div_side_t   side_o
);
  import bpf_pkg::*;

  logic      vld_q;
  div_lane_t lane_p_q, lane_p_d, lane_q_q, lane_q_d;
  div_side_t side_q;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [15:0] dv);
    logic [RemW:0] sh;
    div_lane_t     r;
    sh    = {l.rem, l.num[DivBits-1]};
    r.neg = l.neg;
    if (sh >= {1'b0, dv}) begin
      r.rem = RemW'(sh - {1'b0, dv});
      r.num = {l.num[DivBits-2:0], 1'b1};
    end else begin
      r.rem = sh[RemW-1:0];
      r.num = {l.num[DivBits-2:0], 1'b0};
    end
    return r;
  endfunction

  assign lane_p_d = div_step(lane_p_i, side_i.t);
  assign lane_q_d = div_step(lane_q_i, side_i.t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_p_q <= lane_p_d;
      lane_q_q <= lane_q_d;
      side_q   <= side_i;
    end
  end

  assign vld_o    = vld_q;
  assign lane_p_o = lane_p_q;
  assign lane_q_o = lane_q_q;
  assign side_o   = side_q;

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (lane_p_q.rem < side_q.t && lane_q_q.rem < side_q.t))
    else $error("divider remainder not below divisor");

endmodule

@@ rtl/branch_power_flow_core.sv @@
// top level of the pi-model branch power flow pipeline
//
// one branch record enters per transaction on the in channel (valid/stall)
// and one result with the four flows leaves per transaction on the out
// channel (valid/stall). base_mva is written over the cfg channel, which is
// always ready; write it only while the pipeline is empty. reset sets it to
// 100 and empties every stage.
// a record passes through 71 registers from the in channel to out_valid_o:
// one entry stage, 16 cordic cells, four multiply and round stages, 47
// divider cells (one quotient bit each, set by the width of the from-end
// division), two stages to sum and scale, and the output register.
// throughput is one transaction per cycle. all stages advance together: when
// the output register holds a result and out_stall_i is high, the whole
// pipeline freezes and in_stall_o rises in the same cycle; a taken result
// frees the register so a new record enters in that very cycle.
module branch_power_flow_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [13:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        from_voltage_i,
  input  logic [15:0]        to_voltage_i,
  input  logic signed [15:0] from_angle_i,
  input  logic signed [15:0] to_angle_i,
  input  logic signed [23:0] series_real_i,
  input  logic signed [23:0] series_imag_i,
  input  logic signed [23:0] shunt_charging_i,
  input  logic [15:0]        tap_ratio_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [39:0] from_active_o,
  output logic signed [39:0] from_reactive_o,
  output logic signed [39:0] to_active_o,
  output logic signed [39:0] to_reactive_o
);
  import bpf_pkg::*;

  localparam logic signed [48:0] PuLimit = 49'sd2199023255552;
  localparam logic signed [57:0] OutMax  = 58'sd549755813887;
  localparam logic signed [57:0] OutMin  = -58'sd549755813888;

  // global advance: every stage moves unless a held result is stalled
  logic en;
  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  logic [13:0] base_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 14'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  // ---------------- entry: angle reduction and voltage products ----------
  logic signed [17:0] d0, d1, d2, df;
  logic               neg;
  cord_side_t         side1_d;

  always_comb begin
    d0 = 18'(from_angle_i) - 18'(to_angle_i);
    d1 = d0;
    if (d1 > Q13Pi) d1 = d1 - Q13TwoPi;
    if (d1 < -Q13Pi) d1 = d1 + Q13TwoPi;
    d2 = d1;
    if (d2 > Q13Pi) d2 = d2 - Q13TwoPi;
    if (d2 < -Q13Pi) d2 = d2 + Q13TwoPi;
    // fold into the right half plane, which flips both cos and sin
    neg = 1'b0;
    df  = d2;
    if (d2 > Q13HalfPi) begin
      df  = d2 - Q13Pi;
      neg = 1'b1;
    end else if (d2 < -Q13HalfPi) begin
      df  = d2 + Q13Pi;
      neg = 1'b1;
    end
    side1_d.vff = from_voltage_i * from_voltage_i;
    side1_d.vtt = to_voltage_i * to_voltage_i;
    side1_d.vft = from_voltage_i * to_voltage_i;
    side1_d.g   = series_real_i;
    side1_d.b   = series_imag_i;
    side1_d.bb  = 25'(series_imag_i) - 25'(shunt_charging_i);
    side1_d.t   = (tap_ratio_i == 16'd0) ? TapOne : tap_ratio_i;
    side1_d.neg = neg;
  end

  logic              s1_vld_q;
  logic signed [ZW-1:0] s1_z_q;
  cord_side_t        s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_z_q    <= ZW'(df) <<< 3;   // q13 to q16
      s1_side_q <= side1_d;
    end
  end

  // ---------------- cordic chain -----------------------------------------
  logic                  c_vld  [CordicSteps+1];
  logic signed [XyW-1:0] c_x    [CordicSteps+1];
  logic signed [XyW-1:0] c_y    [CordicSteps+1];
  logic signed [ZW-1:0]  c_z    [CordicSteps+1];
  cord_side_t            c_side [CordicSteps+1];

  assign c_vld[0]  = s1_vld_q;
  assign c_x[0]    = CordicGain;
  assign c_y[0]    = '0;
  assign c_z[0]    = s1_z_q;
  assign c_side[0] = s1_side_q;

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    bpf_cordic_cell #(.Step(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (c_vld[i]),
      .x_i    (c_x[i]),
      .y_i    (c_y[i]),
      .z_i    (c_z[i]),
      .side_i (c_side[i]),
      .vld_o  (c_vld[i+1]),
      .x_o    (c_x[i+1]),
      .y_o    (c_y[i+1]),
      .z_o    (c_z[i+1]),
      .side_o (c_side[i+1])
    );
  end

  // ---------------- s2: clamp cos/sin, first products ---------------------
  cord_side_t         cs;
  logic signed [17:0] cos_v, sin_v, xc, yc;

  always_comb begin
    cs = c_side[CordicSteps];
    xc = 18'(c_x[CordicSteps]);
    yc = 18'(c_y[CordicSteps]);
    if (c_x[CordicSteps] > OneQ16) xc = 18'(OneQ16);
    if (c_x[CordicSteps] < -OneQ16) xc = 18'(-OneQ16);
    if (c_y[CordicSteps] > OneQ16) yc = 18'(OneQ16);
    if (c_y[CordicSteps] < -OneQ16) yc = 18'(-OneQ16);
    cos_v = cs.neg ? -xc : xc;
    sin_v = cs.neg ? -yc : yc;
  end

  logic               s2_vld_q;
  logic signed [56:0] s2_pfg_q, s2_ptg_q;
  logic signed [57:0] s2_pfb_q, s2_ptb_q;
  logic signed [41:0] s2_gc_q, s2_bs_q, s2_gs_q, s2_bc_q;
  logic [31:0]        s2_vft_q;
  logic [15:0]        s2_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= c_vld[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pfg_q <= $signed({1'b0, cs.vff}) * cs.g;
      s2_pfb_q <= $signed({1'b0, cs.vff}) * cs.bb;
      s2_ptg_q <= $signed({1'b0, cs.vtt}) * cs.g;
      s2_ptb_q <= $signed({1'b0, cs.vtt}) * cs.bb;
      s2_gc_q  <= cs.g * cos_v;
      s2_bs_q  <= cs.b * sin_v;
      s2_gs_q  <= cs.g * sin_v;
      s2_bc_q  <= cs.b * cos_v;
      s2_vft_q <= cs.vft;
      s2_t_q   <= cs.t;
    end
  end

  // ---------------- s3: sums, rounding, division numerators --------------
  logic signed [43:0] k_fp, k_fq, k_tp, k_tq;
  logic signed [57:0] r_tg, r_tb;
  logic [56:0]        m_p, m_q;
  logic [57:0]        n_p, n_q;

  always_comb begin
    k_fp = 44'(s2_gc_q) + 44'(s2_bs_q) + 44'sd32768;
    k_fq = 44'(s2_gs_q) - 44'(s2_bc_q) + 44'sd32768;
    k_tp = 44'(s2_gc_q) - 44'(s2_bs_q) + 44'sd32768;
    k_tq = 44'(s2_bc_q) + 44'(s2_gs_q) + 44'sd32768;
    r_tg = 58'(s2_ptg_q) + 58'sd8388608;
    r_tb = s2_ptb_q + 58'sd8388608;
    m_p  = s2_pfg_q[56] ? 57'(-s2_pfg_q) : 57'(s2_pfg_q);
    m_q  = s2_pfb_q[57] ? 57'(-s2_pfb_q) : 57'(s2_pfb_q);
    // half the divisor added first, the /1024 taken out before dividing by t
    n_p  = 58'(m_p) + (58'(s2_t_q) << 9);
    n_q  = 58'(m_q) + (58'(s2_t_q) << 9);
  end

  logic               s3_vld_q;
  logic signed [26:0] s3_kfp_q, s3_kfq_q, s3_ktp_q, s3_ktq_q;
  logic signed [33:0] s3_stp_q, s3_stq_q;
  logic [DivBits-1:0] s3_np_q, s3_nq_q;
  logic               s3_negp_q, s3_negq_q;
  logic [31:0]        s3_vft_q;
  logic [15:0]        s3_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_kfp_q  <= 27'(k_fp >>> 16);
      s3_kfq_q  <= 27'(k_fq >>> 16);
      s3_ktp_q  <= 27'(k_tp >>> 16);
      s3_ktq_q  <= 27'(k_tq >>> 16);
      s3_stp_q  <= 34'(r_tg >>> 24);
      s3_stq_q  <= 34'(r_tb >>> 24);
      s3_np_q   <= DivBits'(n_p >> 10);
      s3_nq_q   <= DivBits'(n_q >> 10);
      s3_negp_q <= s2_pfg_q[56];
      s3_negq_q <= s2_pfb_q[57];
      s3_vft_q  <= s2_vft_q;
      s3_t_q    <= s2_t_q;
    end
  end

  // ---------------- s4: cross and to-end products --------------------------
  logic               s4_vld_q;
  logic signed [59:0] s4_mfp_q, s4_mfq_q, s4_mtp_q, s4_mtq_q;
  logic signed [50:0] s4_stp_q, s4_stq_q;
  logic [DivBits-1:0] s4_np_q, s4_nq_q;
  logic               s4_negp_q, s4_negq_q;
  logic [15:0]        s4_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_mfp_q  <= $signed({1'b0, s3_vft_q}) * s3_kfp_q;
      s4_mfq_q  <= $signed({1'b0, s3_vft_q}) * s3_kfq_q;
      s4_mtp_q  <= $signed({1'b0, s3_vft_q}) * s3_ktp_q;
      s4_mtq_q  <= $signed({1'b0, s3_vft_q}) * s3_ktq_q;
      s4_stp_q  <= s3_stp_q * $signed({1'b0, s3_t_q});
      s4_stq_q  <= s3_stq_q * $signed({1'b0, s3_t_q});
      s4_np_q   <= s3_np_q;
      s4_nq_q   <= s3_nq_q;
      s4_negp_q <= s3_negp_q;
      s4_negq_q <= s3_negq_q;
      s4_t_q    <= s3_t_q;
    end
  end

  // ---------------- s5: round, load the dividers ------------------------
  div_side_t side5_d;
  div_lane_t lane5_p, lane5_q;

  always_comb begin
    side5_d.cr_fp   = 34'((61'(s4_mfp_q) + 61'sd8388608) >>> 24);
    side5_d.cr_fq   = 34'((61'(s4_mfq_q) + 61'sd8388608) >>> 24);
    side5_d.cr_tp   = 34'((61'(s4_mtp_q) + 61'sd8388608) >>> 24);
    side5_d.cr_tq   = 34'((61'(s4_mtq_q) + 61'sd8388608) >>> 24);
    side5_d.self_tp = 36'((52'(s4_stp_q) + 52'sd8192) >>> 14);
    side5_d.self_tq = 36'((52'(s4_stq_q) + 52'sd8192) >>> 14);
    side5_d.t       = s4_t_q;
    lane5_p.rem     = '0;
    lane5_p.num     = s4_np_q;
    lane5_p.neg     = s4_negp_q;
    lane5_q.rem     = '0;
    lane5_q.num     = s4_nq_q;
    lane5_q.neg     = s4_negq_q;
  end

  logic      s5_vld_q;
  div_side_t s5_side_q;
  div_lane_t s5_lp_q, s5_lq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q <= side5_d;
      s5_lp_q   <= lane5_p;
      s5_lq_q   <= lane5_q;
    end
  end

  // ---------------- divider chain: one quotient bit per cell --------------
  logic [DivBits:0] d_vld;
  div_lane_t        d_lp   [DivBits+1];
  div_lane_t        d_lq   [DivBits+1];
  div_side_t        d_side [DivBits+1];

  assign d_vld[0]  = s5_vld_q;
  assign d_lp[0]   = s5_lp_q;
  assign d_lq[0]   = s5_lq_q;
  assign d_side[0] = s5_side_q;

  for (genvar j = 0; j < DivBits; j++) begin : g_div
    bpf_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .vld_i    (d_vld[j]),
      .lane_p_i (d_lp[j]),
      .lane_q_i (d_lq[j]),
      .side_i   (d_side[j]),
      .vld_o    (d_vld[j+1]),
      .lane_p_o (d_lp[j+1]),
      .lane_q_o (d_lq[j+1]),
      .side_o   (d_side[j+1])
    );
  end

  // ---------------- s6: combine terms and clamp per unit -----------------
  function automatic logic signed [42:0] clamp_pu(input logic signed [48:0] v);
    logic signed [42:0] r;
    if (v > PuLimit) r = 43'(PuLimit);
    else if (v < -PuLimit) r = 43'(-PuLimit);
    else r = 43'(v);
    return r;
  endfunction

  div_side_t          ds;
  logic signed [47:0] self_fp, self_fq;

  always_comb begin
    ds      = d_side[DivBits];
    self_fp = d_lp[DivBits].neg ? -48'(d_lp[DivBits].num) : 48'(d_lp[DivBits].num);
    self_fq = d_lq[DivBits].neg ? -48'(d_lq[DivBits].num) : 48'(d_lq[DivBits].num);
  end

  logic               s6_vld_q;
  logic signed [42:0] s6_fa_q, s6_fr_q, s6_ta_q, s6_tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= d_vld[DivBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_fa_q <= clamp_pu(49'(ds.cr_fp) - 49'(self_fp));
      s6_fr_q <= clamp_pu(49'(self_fq) + 49'(ds.cr_fq));
      s6_ta_q <= clamp_pu(49'(ds.cr_tp) - 49'(ds.self_tp));
      s6_tr_q <= clamp_pu(49'(ds.self_tq) - 49'(ds.cr_tq));
    end
  end

  // ---------------- s7: scale by the mva base --------------------------
  logic               s7_vld_q;
  logic signed [57:0] s7_fa_q, s7_fr_q, s7_ta_q, s7_tr_q;
  logic signed [14:0] base_s;

  assign base_s = $signed({1'b0, base_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_fa_q <= s6_fa_q * base_s;
      s7_fr_q <= s6_fr_q * base_s;
      s7_ta_q <= s6_ta_q * base_s;
      s7_tr_q <= s6_tr_q * base_s;
    end
  end

  // ---------------- output register with saturation ---------------------
  function automatic logic signed [39:0] sat_out(input logic signed [57:0] v);
    logic signed [39:0] r;
    if (v > OutMax) r = 40'(OutMax);
    else if (v < OutMin) r = 40'(OutMin);
    else r = 40'(v);
    return r;
  endfunction

  logic               out_vld_q;
  logic signed [39:0] fa_q, fr_q, ta_q, tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fa_q <= sat_out(s7_fa_q);
      fr_q <= sat_out(s7_fr_q);
      ta_q <= sat_out(s7_ta_q);
      tr_q <= sat_out(s7_tr_q);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign from_active_o   = fa_q;
  assign from_reactive_o = fr_q;
  assign to_active_o     = ta_q;
  assign to_reactive_o   = tr_q;

  // an accepted transaction lands in the entry stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_vld_q)
    else $error("accepted transaction lost at entry");

  // a stalled output freezes the divider chain occupancy
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(d_vld))
    else $error("pipeline moved during stall");

  // a zero base gives zero flows
  a_zero_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s7_vld_q && en && base_q == 14'd0 && $stable(base_q) |=>
      (from_active_o == 40'sd0 || !out_valid_o))
    else $error("nonzero flow with zero base");

endmodule
